[hw/rtl/pidsb_pkg.sv]
// Shared types and constants for the PID steering unit with speed bands.
// Holds field widths, register indexes, datapath op codes and the
// controller/datapath command and status structs. No dependencies.
package pidsb_pkg;

    localparam int ERR_W    = 16;
    localparam int DT_W     = 20;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 15;
    localparam int SPEED_W  = 10;
    localparam int STEER_W  = 16;
    localparam int INTEG_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Divider geometry: 64-bit dividend, 20-bit divisor, two bits per cycle.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_CNT_W = 5;

    localparam logic [DT_W-1:0] US_PER_S = 20'd1000000;

    localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [INTEG_W-1:0] INTEG_MIN = 48'h8000_0000_0000;

    localparam logic [STEER_W-1:0] STEER_MAX = 16'h7FFF;
    localparam logic [STEER_W-1:0] STEER_MIN = 16'h8000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MID  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SLOW = 3'd7;

    // Reset values of the band and speed registers
    localparam logic [BAND_W-1:0]  BAND_LOW_RST   = 15'd715;
    localparam logic [BAND_W-1:0]  BAND_HIGH_RST  = 15'd1430;
    localparam logic [SPEED_W-1:0] SPEED_FAST_RST = 10'd150;
    localparam logic [SPEED_W-1:0] SPEED_MID_RST  = 10'd100;
    localparam logic [SPEED_W-1:0] SPEED_SLOW_RST = 10'd50;

    // Datapath operations, one per cycle
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
    localparam logic [OP_W-1:0] OP_MP    = 5'd2;
    localparam logic [OP_W-1:0] OP_MILO  = 5'd3;
    localparam logic [OP_W-1:0] OP_MIHI  = 5'd4;
    localparam logic [OP_W-1:0] OP_MD0   = 5'd5;
    localparam logic [OP_W-1:0] OP_MD1   = 5'd6;
    localparam logic [OP_W-1:0] OP_MTERM = 5'd7;
    localparam logic [OP_W-1:0] OP_DIVI  = 5'd8;
    localparam logic [OP_W-1:0] OP_DIVD  = 5'd9;
    localparam logic [OP_W-1:0] OP_TAKEI = 5'd10;
    localparam logic [OP_W-1:0] OP_TAKED = 5'd11;
    localparam logic [OP_W-1:0] OP_ZEROD = 5'd12;
    localparam logic [OP_W-1:0] OP_SUM1  = 5'd13;
    localparam logic [OP_W-1:0] OP_SUM2  = 5'd14;
    localparam logic [OP_W-1:0] OP_MAG   = 5'd15;
    localparam logic [OP_W-1:0] OP_FIN   = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic fault;
    } t_sts;

endpackage

[hw/rtl/pidsb_div.sv]
// Iterative unsigned divider, restoring, two quotient bits per cycle.
// 64-bit dividend, 20-bit divisor; uses pidsb_pkg.
module pidsb_div import pidsb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DT_W-1:0]      i_den,
    output logic [DIV_NUM_W-1:0] o_quot,
    output logic                 o_done
);

    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [DT_W-1:0]      r_rem, n_rem;
    logic [DT_W-1:0]      r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb begin
        logic [DT_W:0] t;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_num[DIV_NUM_W-1]};
            n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t        = t - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = t[DT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;

endmodule

[hw/rtl/pidsb_dp.sv]
// Datapath: configuration registers, PID state, products, shared divider,
// angle sum and output word registers. Uses pidsb_pkg and pidsb_div.
module pidsb_dp import pidsb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [ERR_W-1:0]   i_dist_error,
    input  logic [DT_W-1:0]           i_dt_us,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic signed [STEER_W-1:0] o_steer_cmd,
    output logic [SPEED_W-1:0]        o_speed_cmd,
    output logic                      o_dt_fault
);

    // Configuration
    logic signed [GAIN_W-1:0] r_gain_prop, r_gain_integ, r_gain_deriv;
    logic [BAND_W-1:0]        r_band_low, r_band_high;
    logic [SPEED_W-1:0]       r_speed_fast, r_speed_mid, r_speed_slow;

    // Controller state carried between words
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;

    // Per-word working registers
    logic signed [ERR_W-1:0]   r_err;
    logic [DT_W-1:0]           r_dt;
    logic signed [ERR_W:0]     r_diff;
    logic                      r_fault;
    logic signed [31:0]        r_p;
    logic signed [40:0]        r_pp;
    logic signed [63:0]        r_iprod;
    logic signed [32:0]        r_dp0;
    logic signed [53:0]        r_dprod;
    logic signed [36:0]        r_term;
    logic signed [43:0]        r_i;
    logic signed [51:0]        r_d;
    logic signed [55:0]        r_sum;
    logic                      r_neg;
    logic [47:0]               r_amag;

    logic signed [39:0]        w_ihi;
    logic [DIV_NUM_W-1:0]      w_imag, w_dmag, w_div_num, w_quot;
    logic [DT_W-1:0]           w_div_den;
    logic                      w_div_start, w_div_done;
    logic signed [43:0]        w_qi;
    logic signed [51:0]        w_qd;
    logic [55:0]               w_sum_mag;
    logic signed [INTEG_W:0]   w_ni;
    logic [INTEG_W-1:0]        w_integ_sat;
    logic [STEER_W-1:0]        w_steer;
    logic [SPEED_W-1:0]        w_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= '0;
            r_gain_integ <= '0;
            r_gain_deriv <= '0;
            r_band_low   <= BAND_LOW_RST;
            r_band_high  <= BAND_HIGH_RST;
            r_speed_fast <= SPEED_FAST_RST;
            r_speed_mid  <= SPEED_MID_RST;
            r_speed_slow <= SPEED_SLOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                CFG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                CFG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                CFG_BAND_LOW:   r_band_low   <= i_cfg_data[BAND_W-1:0];
                CFG_BAND_HIGH:  r_band_high  <= i_cfg_data[BAND_W-1:0];
                CFG_SPEED_FAST: r_speed_fast <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_MID:  r_speed_mid  <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_SLOW: r_speed_slow <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Integral product, upper half of the split integral
    assign w_ihi = r_gain_integ * $signed(r_integ[INTEG_W-1:24]);

    // Divider operands: |I product| / 1e6 or |D product| / dt
    assign w_imag    = r_iprod[63] ? (~r_iprod + 64'd1) : r_iprod;
    assign w_dmag    = {10'd0, (r_dprod[53] ? (~r_dprod + 54'd1) : r_dprod)};
    assign w_div_num = (i_cmd.op == OP_DIVD) ? w_dmag : w_imag;
    assign w_div_den = (i_cmd.op == OP_DIVD) ? r_dt : US_PER_S;
    assign w_div_start = (i_cmd.op == OP_DIVI) || (i_cmd.op == OP_DIVD);

    pidsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // Quotient magnitudes: the take steps restore the signs, so quotients truncate toward zero
    assign w_qi = $signed({1'b0, w_quot[42:0]});
    assign w_qd = $signed({1'b0, w_quot[50:0]});

    assign w_sum_mag = r_sum[55] ? (~r_sum + 56'd1) : r_sum;

    // Integral update with saturation to 48 bits
    assign w_ni = {r_integ[INTEG_W-1], r_integ}
                + {{(INTEG_W-36){r_term[36]}}, r_term};
    always_comb begin
        if (w_ni[INTEG_W] != w_ni[INTEG_W-1]) begin
            w_integ_sat = w_ni[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            w_integ_sat = w_ni[INTEG_W-1:0];
        end
    end

    // Steering is the negated angle: a negative sum steers positive
    always_comb begin
        if (r_neg) begin
            w_steer = (r_amag > {32'd0, STEER_MAX}) ? STEER_MAX : r_amag[STEER_W-1:0];
        end else begin
            w_steer = (r_amag > {32'd0, STEER_MIN}) ? STEER_MIN
                                                    : (~r_amag[STEER_W-1:0] + 16'd1);
        end
    end

    always_comb begin
        if (r_amag <= {33'd0, r_band_low}) begin
            w_speed = r_speed_fast;
        end else if (r_amag <= {33'd0, r_band_high}) begin
            w_speed = r_speed_mid;
        end else begin
            w_speed = r_speed_slow;
        end
    end

    // State held across words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_cmd.op == OP_FIN) begin
            r_integ    <= w_integ_sat;
            r_last_err <= r_err;
        end
    end

    // Working registers and output word
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_err   <= i_dist_error;
                r_dt    <= i_dt_us;
                r_diff  <= {i_dist_error[ERR_W-1], i_dist_error}
                         - {r_last_err[ERR_W-1], r_last_err};
                r_fault <= (i_dt_us == '0);
            end
            OP_MP:    r_p     <= r_gain_prop * r_err;
            OP_MILO:  r_pp    <= r_gain_integ * $signed({1'b0, r_integ[23:0]});
            OP_MIHI:  r_iprod <= $signed({w_ihi, 24'd0}) + $signed({{23{r_pp[40]}}, r_pp});
            OP_MD0:   r_dp0   <= r_gain_deriv * r_diff;
            OP_MD1:   r_dprod <= r_dp0 * $signed({1'b0, US_PER_S});
            OP_MTERM: r_term  <= r_err * $signed({1'b0, r_dt});
            OP_TAKEI: r_i     <= r_iprod[63] ? -w_qi : w_qi;
            OP_TAKED: r_d     <= r_dprod[53] ? -w_qd : w_qd;
            OP_ZEROD: r_d     <= '0;
            OP_SUM1:  r_sum   <= {{24{r_p[31]}}, r_p} + {{12{r_i[43]}}, r_i};
            OP_SUM2:  r_sum   <= r_sum + {{4{r_d[51]}}, r_d};
            OP_MAG: begin
                r_neg  <= r_sum[55];
                r_amag <= w_sum_mag[55:8];
            end
            OP_FIN: begin
                o_steer_cmd <= w_steer;
                o_speed_cmd <= w_speed;
                o_dt_fault  <= r_fault;
            end
            default: ;
        endcase
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.fault    = r_fault;

endmodule

[hw/rtl/pidsb_ctrl.sv]
// Controller: sequences one word through the datapath and owns both
// handshakes. Uses pidsb_pkg.
module pidsb_ctrl import pidsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MP     = 4'd1;
    localparam logic [3:0] ST_MILO   = 4'd2;
    localparam logic [3:0] ST_MIHI   = 4'd3;
    localparam logic [3:0] ST_MD0    = 4'd4;
    localparam logic [3:0] ST_MD1    = 4'd5;
    localparam logic [3:0] ST_MTERM  = 4'd6;
    localparam logic [3:0] ST_DIVI   = 4'd7;
    localparam logic [3:0] ST_WAITI  = 4'd8;
    localparam logic [3:0] ST_DIVD   = 4'd9;
    localparam logic [3:0] ST_WAITD  = 4'd10;
    localparam logic [3:0] ST_SUM1   = 4'd11;
    localparam logic [3:0] ST_SUM2   = 4'd12;
    localparam logic [3:0] ST_MAG    = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MP;
                end
            end
            ST_MP:    begin o_cmd.op = OP_MP;    n_state = ST_MILO;  end
            ST_MILO:  begin o_cmd.op = OP_MILO;  n_state = ST_MIHI;  end
            ST_MIHI:  begin o_cmd.op = OP_MIHI;  n_state = ST_MD0;   end
            ST_MD0:   begin o_cmd.op = OP_MD0;   n_state = ST_MD1;   end
            ST_MD1:   begin o_cmd.op = OP_MD1;   n_state = ST_MTERM; end
            ST_MTERM: begin o_cmd.op = OP_MTERM; n_state = ST_DIVI;  end
            ST_DIVI:  begin o_cmd.op = OP_DIVI;  n_state = ST_WAITI; end
            ST_WAITI: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_TAKEI;
                    n_state  = ST_DIVD;
                end
            end
            ST_DIVD: begin
                // zero elapsed time: drop the derivative, skip the divide
                if (i_sts.fault) begin
                    o_cmd.op = OP_ZEROD;
                    n_state  = ST_SUM1;
                end else begin
                    o_cmd.op = OP_DIVD;
                    n_state  = ST_WAITD;
                end
            end
            ST_WAITD: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_TAKED;
                    n_state  = ST_SUM1;
                end
            end
            ST_SUM1: begin o_cmd.op = OP_SUM1; n_state = ST_SUM2; end
            ST_SUM2: begin o_cmd.op = OP_SUM2; n_state = ST_MAG;  end
            ST_MAG:  begin o_cmd.op = OP_MAG;  n_state = ST_FIN;  end
            ST_FIN: begin
                // hold until the output register can take the word
                if (w_out_free) begin
                    o_cmd.op = OP_FIN;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.op == OP_FIN) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/pid_steering_with_speed_bands_unit.sv]
// PID steering unit with speed bands: top level joining controller and datapath.
// One word at a time: o_in_stall stays high from its load until the final step returns to idle.
// The shared divider serves the integral term and then the derivative term; with zero dt the
// derivative divide is skipped.
// Reset (i_rst_n low, synchronous): gains zero, band/speed registers to defaults,
// integral and last error cleared, no output word pending.
module pid_steering_with_speed_bands_unit import pidsb_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // input word
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [ERR_W-1:0]   i_dist_error,
    input  logic [DT_W-1:0]           i_dt_us,
    // output word
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [STEER_W-1:0] o_steer_cmd,
    output logic [SPEED_W-1:0]        o_speed_cmd,
    output logic                      o_dt_fault
);

    // The controller walks each word through the datapath one operation per
    // cycle except in divider and output waits: load, six multiply steps, the
    // integral divide by one million, the derivative divide by dt, two sum steps,
    // magnitude, and a final step that writes the output register and updates the state.
    t_cmd w_cmd;
    t_sts w_sts;

    pidsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The output register parts the two sides: a new word is taken while
    // the previous result still waits on a stalled consumer.
    pidsb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_dist_error (i_dist_error),
        .i_dt_us      (i_dt_us),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_steer_cmd  (o_steer_cmd),
        .o_speed_cmd  (o_speed_cmd),
        .o_dt_fault   (o_dt_fault)
    );

endmodule

[tb/pid_steering_with_speed_bands_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pid_steering_with_speed_bands_unit: directed table, random phases
// and a quiet tail; output words are checked against an in-bench PID predictor or typed rows.
// Depends on pidsb_pkg and the unit itself; no files or arguments needed.
module pid_steering_with_speed_bands_unit_tb;
    import pidsb_pkg::*;

    // Q36.12 metre-microsecond integral limits (48-bit signed)
    localparam longint INTEG_HI = 64'sd140737488355327;
    localparam longint INTEG_LO = -64'sd140737488355328;
    localparam int     NUM_DIR  = 45;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic [SPEED_W-1:0]        speed;
        logic                      fault;
    } t_steer_word;

    typedef enum logic {ROW_CFG, ROW_WORD} t_row_kind;

    // One directed step: a register write, or an input word with an optional
    // hand-typed expectation (xs/xv/xf) that replaces the predicted one.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           val;
        logic [DT_W-1:0]       dt;
        logic                  typed;
        logic [STEER_W-1:0]    xs;
        logic [SPEED_W-1:0]    xv;
        logic                  xf;
    } t_dir_row;

    // Every input starts at a known value
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index  = CFG_GAIN_PROP;
    logic [CFG_DATA_W-1:0]     i_cfg_data   = '0;
    logic                      i_in_valid   = 1'b0;
    logic signed [ERR_W-1:0]   i_dist_error = '0;
    logic [DT_W-1:0]           i_dt_us      = '0;
    logic                      i_out_stall  = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [STEER_W-1:0] o_steer_cmd;
    logic [SPEED_W-1:0]        o_speed_cmd;
    logic                      o_dt_fault;

    // Predictor copy of the registers and the controller state
    longint             gain_p    = 0;
    longint             gain_i    = 0;
    longint             gain_d    = 0;
    longint             band_lo   = BAND_LOW_RST;
    longint             band_hi   = BAND_HIGH_RST;
    logic [SPEED_W-1:0] spd_fast  = SPEED_FAST_RST;
    logic [SPEED_W-1:0] spd_mid   = SPEED_MID_RST;
    logic [SPEED_W-1:0] spd_slow  = SPEED_SLOW_RST;
    longint             integ_acc = 0;
    longint             prev_err  = 0;

    t_steer_word steer_words_due[$];   // predicted words, oldest first
    int          mismatches = 0;
    bit          quiet      = 1'b0;    // no idling on either side when set
    int unsigned stall_run  = 0;

    // Directed steps. The first four run on reset settings with zero gains, so
    // the angle is zero: steering 0, fast speed, fault only on zero dt.
    t_dir_row dir_rows [NUM_DIR] = '{
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0000, 20'h00000, 1'b1, 16'h0000, SPEED_FAST_RST, 1'b1},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h7FFF, 20'hFFFFF, 1'b1, 16'h0000, SPEED_FAST_RST, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h8000, 20'h00001, 1'b1, 16'h0000, SPEED_FAST_RST, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0001, 20'hF4240, 1'b1, 16'h0000, SPEED_FAST_RST, 1'b0},
        // unity proportional gain: angle equals error, probe both band edges
        '{ROW_CFG,  CFG_GAIN_PROP,  16'h0100, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_BAND_LOW,   16'h03E8, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_BAND_HIGH,  16'h07D0, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h03E8, 20'h00040, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h03E9, 20'h00040, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'hF830, 20'h00040, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'hF82F, 20'h00040, 1'b0, 16'h0000, 10'd0, 1'b0},
        // extreme gains, speed data with upper bits set: steering saturates
        '{ROW_CFG,  CFG_GAIN_PROP,  16'h7FFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_INTEG, 16'h7FFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_DERIV, 16'h8000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_FAST, 16'hFFFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_MID,  16'h0000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_SLOW, 16'h03E8, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h7FFF, 20'h00001, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h8000, 20'h00001, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h8000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0000, 20'hFFFFF, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0010, 20'h003E8, 1'b0, 16'h0000, 10'd0, 1'b0},
        // band limits out of order (low 2000 with bit 15 set, high 500)
        '{ROW_CFG,  CFG_BAND_LOW,   16'h87D0, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_BAND_HIGH,  16'h01F4, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_PROP,  16'h0100, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_INTEG, 16'h0001, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_DERIV, 16'h0000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0200, 20'h001F4, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'hFE00, 20'h001F4, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0900, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h7FFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        // opposite extremes, widest bands, speed data with low bits all zero or all one
        '{ROW_CFG,  CFG_BAND_LOW,   16'h0000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_BAND_HIGH,  16'h7FFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_PROP,  16'h8000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_INTEG, 16'h8000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_GAIN_DERIV, 16'h7FFF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_FAST, 16'h0000, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_MID,  16'h03FF, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_CFG,  CFG_SPEED_SLOW, 16'hFC00, 20'h00000, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0000, 20'h00001, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h0001, 20'h00003, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'hFFFF, 20'h00007, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'h4000, 20'h13880, 1'b0, 16'h0000, 10'd0, 1'b0},
        '{ROW_WORD, CFG_GAIN_PROP,  16'hC000, 20'hFFFFF, 1'b0, 16'h0000, 10'd0, 1'b0}
    };

    pid_steering_with_speed_bands_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_dist_error (i_dist_error),
        .i_dt_us      (i_dt_us),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_steer_cmd  (o_steer_cmd),
        .o_speed_cmd  (o_speed_cmd),
        .o_dt_fault   (o_dt_fault)
    );

    always #4 i_clk = ~i_clk;

    // Run one controller step: PID angle from the integral held before this
    // step, speed band from the full-width magnitude, then advance the state.
    function automatic t_steer_word predict_steering(input logic signed [ERR_W-1:0] err,
                                                     input logic [DT_W-1:0] dt);
        longint      e;
        longint      dtl;
        longint      p_term;
        longint      i_term;
        longint      d_term;
        longint      angle;
        longint      steer;
        longint      amag;
        longint      next_integ;
        t_steer_word w;
        e      = err;
        dtl    = dt;
        p_term = gain_p * e;
        i_term = (gain_i * integ_acc) / 64'sd1000000;
        // zero elapsed time: no derivative, flag it
        if (dtl == 0) d_term = 0;
        else          d_term = (gain_d * (e - prev_err) * 64'sd1000000) / dtl;
        angle = (p_term + i_term + d_term) / 64'sd256;
        steer = -angle;
        if (steer > 32767)  steer = 32767;
        if (steer < -32768) steer = -32768;
        amag = (angle < 0) ? -angle : angle;
        if (amag <= band_lo)      w.speed = spd_fast;
        else if (amag <= band_hi) w.speed = spd_mid;
        else                      w.speed = spd_slow;
        w.steer = steer[STEER_W-1:0];
        w.fault = (dtl == 0);
        next_integ = integ_acc + e * dtl;
        if (next_integ > INTEG_HI) next_integ = INTEG_HI;
        if (next_integ < INTEG_LO) next_integ = INTEG_LO;
        integ_acc = next_integ;
        prev_err  = e;
        return w;
    endfunction

    // Write one register once the unit has drained, and mirror it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic signed [15:0] sdata;
        i_in_valid <= 1'b0;
        while (steer_words_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sdata = data;
        case (idx)
            CFG_GAIN_PROP:  gain_p   = sdata;
            CFG_GAIN_INTEG: gain_i   = sdata;
            CFG_GAIN_DERIV: gain_d   = sdata;
            CFG_BAND_LOW:   band_lo  = data[BAND_W-1:0];
            CFG_BAND_HIGH:  band_hi  = data[BAND_W-1:0];
            CFG_SPEED_FAST: spd_fast = data[SPEED_W-1:0];
            CFG_SPEED_MID:  spd_mid  = data[SPEED_W-1:0];
            CFG_SPEED_SLOW: spd_slow = data[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one input word, optionally after an idle burst; hold it until
    // taken, then queue its prediction (or the typed expectation).
    task automatic send_word(input logic [ERR_W-1:0] err, input logic [DT_W-1:0] dt,
                             input bit typed, input t_steer_word typed_word);
        t_steer_word due;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_dist_error <= err;
        i_dt_us      <= dt;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        due = predict_steering(err, dt);
        steer_words_due.push_back(typed ? typed_word : due);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2:       return 16'h0000;
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_band();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_speed();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'h03FF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 1000));
        endcase
    endfunction

    // Random word: mostly small, realistic errors and scan periods, with
    // extremes, zero dt and full-width noise mixed in.
    task automatic send_random_word();
        logic [ERR_W-1:0] err;
        logic [DT_W-1:0]  dt;
        t_steer_word      unused;
        case ($urandom_range(0, 5))
            0:       err = 16'($urandom_range(0, 65535));
            1:       err = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            2, 3:    err = 16'(int'($urandom_range(0, 4000)) - 2000);
            4:       err = 16'(int'($urandom_range(0, 16)) - 8);
            default: err = '0;
        endcase
        case ($urandom_range(0, 7))
            0:       dt = '0;
            1:       dt = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom_range(0, 1048575));
            2:       dt = 20'($urandom_range(1, 100));
            default: dt = 20'($urandom_range(10000, 100000));
        endcase
        unused = '0;
        send_word(err, dt, 1'b0, unused);
    endtask

    // Receiver stall: bursts of random length between free stretches;
    // hold low in the quiet part of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_run   <= $urandom_range(0, 40);
        end else begin
            i_out_stall <= 1'b1;
            stall_run   <= $urandom_range(0, 14);
        end
    end

    // Check each accepted output word against the oldest prediction.
    always @(posedge i_clk) begin
        t_steer_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (steer_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output word: steer %0d speed %0d fault %0b",
                             $realtime, o_steer_cmd, o_speed_cmd, o_dt_fault);
            end else begin
                want = steer_words_due.pop_front();
                if (o_steer_cmd !== want.steer || o_speed_cmd !== want.speed
                        || o_dt_fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: steer exp %0d got %0d, speed exp %0d got %0d,",
                                  " fault exp %0b got %0b"},
                                 $realtime, want.steer, o_steer_cmd, want.speed, o_speed_cmd,
                                 want.fault, o_dt_fault);
                end
            end
        end
    end

    initial begin
        t_steer_word typed_word;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int k = 0; k < NUM_DIR; k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_reg(dir_rows[k].idx, dir_rows[k].val);
            end else begin
                typed_word.steer = dir_rows[k].xs;
                typed_word.speed = dir_rows[k].xv;
                typed_word.fault = dir_rows[k].xf;
                send_word(dir_rows[k].val, dir_rows[k].dt, dir_rows[k].typed, typed_word);
            end
        end

        // Random phases, each under fresh settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_GAIN_PROP, rand_gain());
            write_reg(CFG_GAIN_INTEG, rand_gain());
            write_reg(CFG_GAIN_DERIV, rand_gain());
            write_reg(CFG_BAND_LOW, rand_band());
            write_reg(CFG_BAND_HIGH, rand_band());
            write_reg(CFG_SPEED_FAST, rand_speed());
            write_reg(CFG_SPEED_MID, rand_speed());
            write_reg(CFG_SPEED_SLOW, rand_speed());
            for (int n = 0; n < 85; n++) send_random_word();
        end

        // Quiet tail: no idling on either side, words back to back
        quiet = 1'b1;
        for (int n = 0; n < 50; n++) send_random_word();
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle before the verdict
        while (steer_words_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: several times the slowest correct run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[pid_steering_with_speed_bands_unit.f]
hw/rtl/pidsb_pkg.sv
hw/rtl/pidsb_div.sv
hw/rtl/pidsb_dp.sv
hw/rtl/pidsb_ctrl.sv
hw/rtl/pid_steering_with_speed_bands_unit.sv
tb/pid_steering_with_speed_bands_unit_tb.sv
